// ----- sv/first_substring_match_assert.svh -----
// Assertion macros shared by the search block.
`ifndef FIRST_SUBSTRING_MATCH_ASSERT_SVH
`define FIRST_SUBSTRING_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted
`define FSS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("first_substring_match: check failed");
// Clocked check that also holds during reset
`define FSS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("first_substring_match: check failed");
`else
`define FSS_ASSERT(lbl, clk, rstn, prop)
`define FSS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- sv/fss_pkg.sv -----
package fss_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PATTERN_DEF = 16;
	localparam int INDEX_BITS_DEF  = 32;

	// Configuration port geometry
	localparam int CFG_ADDR_W  = 5;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_REG_W   = 5;
	localparam int PAT_BYTES   = 16;
	localparam int MATCH_START_W = 32;

	// Register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2
	} reg_idx_t;

	// Input word: one text byte plus framing
	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
	} text_word_t;

	// Result word
	typedef struct packed {
		logic                     found;
		logic [MATCH_START_W-1:0] match_start;
	} result_word_t;

	// Pattern setup handed from the register block to the matcher
	typedef struct packed {
		logic [8*PAT_BYTES-1:0] bytes;
		logic [LEN_REG_W-1:0]   length;
	} pattern_cfg_t;

endpackage

// ----- sv/fss_cfg.sv -----
module fss_cfg
	import fss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output pattern_cfg_t          pattern
);

	logic [63:0]          pat_lo_q;
	logic [63:0]          pat_hi_q;
	logic [LEN_REG_W-1:0] pat_len_q;
	logic                 wr_en;
	reg_idx_t             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[4:3]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PAT_LO:  pat_lo_q  <= pwdata;
				REG_PAT_HI:  pat_hi_q  <= pwdata;
				REG_PAT_LEN: pat_len_q <= pwdata[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		case (reg_sel)
			REG_PAT_LO:  prdata = pat_lo_q;
			REG_PAT_HI:  prdata = pat_hi_q;
			REG_PAT_LEN: prdata = CFG_DATA_W'(pat_len_q);
			default:     prdata = '0;
		endcase
	end

	assign pattern.bytes  = {pat_hi_q, pat_lo_q};
	assign pattern.length = pat_len_q;

endmodule

// ----- sv/fss_match.sv -----
module fss_match
	import fss_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  text_word_t   item,
	input  pattern_cfg_t pattern,
	output result_word_t result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [7:0]            win_q [MAX_PATTERN];
	logic [7:0]            win_n [MAX_PATTERN];
	logic [7:0]            pat   [MAX_PATTERN];
	logic [INDEX_BITS-1:0] seen_q;
	logic [INDEX_BITS-1:0] seen_n;
	logic                  matched_q;
	logic [INDEX_BITS-1:0] first_q;
	logic [LEN_W-1:0]      len;
	logic [MAX_PATTERN-1:0] hit_by_len;
	logic                  ok;
	logic                  hit_sel;
	logic                  saturated;
	logic                  hit;
	logic [INDEX_BITS-1:0] hit_start;
	logic                  matched_n;
	logic [INDEX_BITS-1:0] start_n;
	logic [63:0]           start_ext;

	// Effective pattern length, clamped to the window depth
	always_comb begin
		if (pattern.length > LEN_REG_W'(MAX_PATTERN))
			len = LEN_W'(MAX_PATTERN);
		else
			len = LEN_W'(pattern.length);
	end

	// Window after taking the new byte; entry 0 is newest
	always_comb begin
		win_n[0] = item.text_byte;
		for (int i = 1; i < MAX_PATTERN; i++)
			win_n[i] = win_q[i-1];
		for (int j = 0; j < MAX_PATTERN; j++)
			pat[j] = pattern.bytes[8*j +: 8];
	end

	// All candidate lengths compared in parallel
	always_comb begin
		hit_by_len = '0;
		for (int l = 0; l < MAX_PATTERN; l++) begin
			ok = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (j <= l) begin
					if (win_n[l-j] != pat[j])
						ok = 1'b0;
				end
			end
			hit_by_len[l] = ok;
		end
		hit_sel = 1'b0;
		for (int l = 0; l < MAX_PATTERN; l++) begin
			if (LEN_W'(l + 1) == len)
				hit_sel = hit_by_len[l];
		end
	end

	// Count, match decision and result for this word
	always_comb begin
		saturated = &seen_q;
		seen_n    = seen_q + INDEX_BITS'(1);
		hit_start = seen_n - INDEX_BITS'(len);
		hit       = item.byte_present && !saturated && !matched_q && (len != '0) &&
			(seen_n >= INDEX_BITS'(len)) && hit_sel;
		matched_n = matched_q || hit;
		start_n   = matched_q ? first_q : hit_start;
		start_ext = 64'(start_n);
		result.found       = (len == '0) || matched_n;
		result.match_start = ((len != '0) && matched_n) ? start_ext[MATCH_START_W-1:0] : '0;
	end

	// Text state: window, byte count, first match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= '0;
			seen_q    <= '0;
			matched_q <= 1'b0;
			first_q   <= '0;
		end else if (fire) begin
			if (item.end_of_text) begin
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= '0;
				seen_q    <= '0;
				matched_q <= 1'b0;
				first_q   <= '0;
			end else if (item.byte_present) begin
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= win_n[i];
				if (!saturated)
					seen_q <= seen_n;
				if (hit) begin
					matched_q <= 1'b1;
					first_q   <= hit_start;
				end
			end
		end
	end

endmodule

// ----- sv/first_substring_match.sv -----
// Streaming first-occurrence substring search. Text arrives one byte per word
// on the text channel; a word with end_of_text set closes the text and yields
// one result word (found, match_start), after which the search state clears.
// The pattern (up to MAX_PATTERN bytes, length 0 = empty pattern, which always
// matches at 0) must be set over the APB port while the block is idle; the
// block does not enforce this. Throughput is one text word per cycle: every
// window position is compared against the pattern in parallel in the single
// stage between the input register and the result register. A result word
// is registered when its end word leaves the input register. The text
// channel stalls only while an end word waits in the input register behind
// a result that still sits unread in the result register. The byte count
// saturates at 2^INDEX_BITS-1; matches ending beyond that are not reported.
`include "first_substring_match_assert.svh"

module first_substring_match
	import fss_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// text channel
	input  logic                  text_valid,
	output logic                  text_stall,
	input  text_word_t            text,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_word_t          result,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic         valid_s1;
	text_word_t   item_s1;
	logic         fire_s1;
	pattern_cfg_t pattern;
	result_word_t res_s1;

	fss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pattern (pattern)
	);

	// Stage 1 word advances unless it is an end word with the result slot full
	assign fire_s1    = valid_s1 && (!item_s1.end_of_text || !result_valid || !result_stall);
	assign text_stall = valid_s1 && !fire_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall)
			item_s1 <= text;
	end

	fss_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.INDEX_BITS  (INDEX_BITS)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire_s1),
		.item    (item_s1),
		.pattern (pattern),
		.result  (res_s1)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fire_s1 && item_s1.end_of_text) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.end_of_text)
			result <= res_s1;
	end

	`FSS_ASSERT(a_nofind_zero_start, clk, arst_n, result_valid && !result.found |-> result.match_start == '0)
	`FSS_ASSERT(a_result_from_end, clk, arst_n, $rose(result_valid) |-> $past(fire_s1 && item_s1.end_of_text))
	`FSS_ASSERT(a_empty_pattern_found, clk, arst_n, result_valid && pattern.length == '0 |-> result.found)
	`FSS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !result_valid && !valid_s1)

endmodule
